// ===== design/shared_exclusive_lock_table_top_assert.svh =====
// Assertion macros shared by the lock table RTL.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_TOP_ASSERT_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_TOP_ASSERT_SVH

// Same-cycle implication
`define SELT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SELT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/selt_pkg.sv =====
`default_nettype none

package selt_pkg;

  // Table geometry
  localparam int unsigned TableSlots = 32;
  localparam int unsigned IdxW       = $clog2(TableSlots);
  localparam int unsigned CntW       = $clog2(TableSlots + 1);

  // Request codes
  typedef enum logic [2:0] {
    OP_ACQUIRE = 3'd0,
    OP_RELEASE = 3'd1,
    OP_REL_ALL = 3'd2,
    OP_HAS     = 3'd3,
    OP_LIST    = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_WAIT = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] page;
    logic [31:0] txn;
    logic        want_exclusive;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        held;
    logic [31:0] page_out;
    logic        last;
  } rsp_t;

  // One slot of the lock table as stored in memory
  typedef struct packed {
    logic [31:0] page;
    logic [31:0] txn;
    logic        excl;
    logic        granted;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/shared_exclusive_lock_table_top.sv =====
// Channel | Direction | Handshake                | Payload
// request | in        | in_valid_i / in_ready_o  | in_item_i  (opcode, page, txn, want_exclusive)
// result  | out       | out_valid_o / out_ready_i| out_item_o (status, held, page_out, last)
//
// One request at a time; defined opcodes scan the slot memory, one read per cycle through
// its single read port while no list result stalls the scan; undefined opcodes skip the scan.
// List requests emit one result per page granted to the transaction, or one empty result if
// there is none; a result stalled at the output holds the scan until the previous one is taken.
// Reset clears the valid flags of all slots at once; slot contents are not cleared.
// The next request is accepted as soon as the last result sits in the output register.
`default_nettype none

`include "shared_exclusive_lock_table_top_assert.svh"

module shared_exclusive_lock_table_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  selt_pkg::req_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output selt_pkg::rsp_t   out_item_o
);
  import selt_pkg::*;

  state_e                state_q, state_d;
  req_t                  req_q, req_d;
  logic [CntW-1:0]       iss_cnt_q, iss_cnt_d;
  logic                  s2_vld_q, s2_vld_d;
  logic [IdxW-1:0]       s2_idx_q, s2_idx_d;
  logic [TableSlots-1:0] valid_q, valid_d;
  logic                  own_found_q, own_found_d;
  logic [IdxW-1:0]       own_idx_q, own_idx_d;
  logic                  own_excl_q, own_excl_d;
  logic                  own_gnt_q, own_gnt_d;
  logic                  free_found_q, free_found_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic                  conf_any_q, conf_any_d;
  logic                  conf_excl_q, conf_excl_d;
  logic                  has_q, has_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [31:0]           pend_page_q, pend_page_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_q, out_d;

  logic                  in_accept;
  logic                  out_free;
  logic                  slot_v;
  logic                  hit_page;
  logic                  hit_txn;
  logic                  list_hit;
  logic                  stall;
  logic                  iss_go;
  logic                  s2_last;
  entry_t                rd_entry;
  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  entry_t                ram_wdata;

  // Slot storage
  selt_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (iss_go),
    .raddr_i (iss_cnt_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // Handshake and scan control
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign slot_v   = valid_q[s2_idx_q];
  assign hit_page = (rd_entry.page == req_q.page);
  assign hit_txn  = (rd_entry.txn == req_q.txn);
  assign list_hit = s2_vld_q && slot_v && rd_entry.granted && hit_txn &&
                    (req_q.opcode == OP_LIST);
  assign stall    = list_hit && pend_vld_q && !out_free;
  assign iss_go   = (state_q == ST_SCAN) && !stall && (iss_cnt_q != CntW'(TableSlots));
  assign s2_last  = s2_vld_q && (s2_idx_q == IdxW'(TableSlots - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_item_i.opcode inside {OP_ACQUIRE, OP_RELEASE, OP_REL_ALL, OP_HAS, OP_LIST})
          begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (s2_last && !stall) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Scan, decision and write-back
  always_comb begin
    logic g;
    rsp_t rsp;

    g            = 1'b0;
    rsp          = '0;
    req_d        = req_q;
    iss_cnt_d    = iss_cnt_q;
    s2_vld_d     = s2_vld_q;
    s2_idx_d     = s2_idx_q;
    valid_d      = valid_q;
    own_found_d  = own_found_q;
    own_idx_d    = own_idx_q;
    own_excl_d   = own_excl_q;
    own_gnt_d    = own_gnt_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    conf_any_d   = conf_any_q;
    conf_excl_d  = conf_excl_q;
    has_d        = has_q;
    pend_vld_d   = pend_vld_q;
    pend_page_d  = pend_page_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = own_idx_q;
    ram_wdata    = '0;

    case (state_q)
      ST_IDLE: begin
        // Latch the request and clear scan results
        if (in_accept) begin
          req_d        = in_item_i;
          iss_cnt_d    = '0;
          s2_vld_d     = 1'b0;
          own_found_d  = 1'b0;
          free_found_d = 1'b0;
          conf_any_d   = 1'b0;
          conf_excl_d  = 1'b0;
          has_d        = 1'b0;
          pend_vld_d   = 1'b0;
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          // Advance the read pipeline
          if (iss_go) begin
            iss_cnt_d = iss_cnt_q + CntW'(1);
          end
          s2_vld_d = iss_go;
          s2_idx_d = iss_cnt_q[IdxW-1:0];

          // Evaluate the slot read issued at the last advance of the pipeline
          if (s2_vld_q) begin
            case (req_q.opcode)
              OP_ACQUIRE: begin
                if (slot_v) begin
                  if (!own_found_q && hit_page && hit_txn) begin
                    own_found_d = 1'b1;
                    own_idx_d   = s2_idx_q;
                    own_excl_d  = rd_entry.excl;
                    own_gnt_d   = rd_entry.granted;
                  end
                  if (rd_entry.granted && hit_page) begin
                    conf_any_d = 1'b1;
                    if (rd_entry.excl) begin
                      conf_excl_d = 1'b1;
                    end
                  end
                end else if (!free_found_q) begin
                  free_found_d = 1'b1;
                  free_idx_d   = s2_idx_q;
                end
              end
              OP_RELEASE: begin
                if (slot_v && hit_txn && hit_page) begin
                  valid_d[s2_idx_q] = 1'b0;
                end
              end
              OP_REL_ALL: begin
                if (slot_v && hit_txn) begin
                  valid_d[s2_idx_q] = 1'b0;
                end
              end
              OP_HAS: begin
                if (slot_v && rd_entry.granted && hit_page && hit_txn) begin
                  has_d = 1'b1;
                end
              end
              OP_LIST: begin
                // Emit the held page once a later one proves it is not last
                if (list_hit) begin
                  if (pend_vld_q) begin
                    out_valid_d       = 1'b1;
                    out_d             = '0;
                    out_d.status      = STAT_OK;
                    out_d.held        = 1'b1;
                    out_d.page_out    = pend_page_q;
                    out_d.last        = 1'b0;
                  end
                  pend_vld_d  = 1'b1;
                  pend_page_d = rd_entry.page;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_FINISH: begin
        rsp        = '0;
        rsp.status = STAT_OK;
        rsp.last   = 1'b1;
        case (req_q.opcode)
          OP_ACQUIRE: begin
            if (own_found_q) begin
              // Upgrade a shared entry when nothing on the page is granted
              if (!own_excl_q && req_q.want_exclusive && !conf_any_q) begin
                ram_we    = out_free;
                ram_waddr = own_idx_q;
                ram_wdata = '{page: req_q.page, txn: req_q.txn, excl: 1'b1,
                              granted: own_gnt_q};
              end else begin
                rsp.status = own_gnt_q ? STAT_OK : STAT_WAIT;
              end
            end else if (!free_found_q) begin
              rsp.status = STAT_FULL;
            end else begin
              // Fill the lowest free slot
              g          = req_q.want_exclusive ? !conf_any_q : !conf_excl_q;
              ram_we     = out_free;
              ram_waddr  = free_idx_q;
              ram_wdata  = '{page: req_q.page, txn: req_q.txn,
                             excl: req_q.want_exclusive, granted: g};
              rsp.status = g ? STAT_OK : STAT_WAIT;
              if (out_free) begin
                valid_d[free_idx_q] = 1'b1;
              end
            end
          end
          OP_HAS: begin
            rsp.held = has_q;
          end
          OP_LIST: begin
            if (pend_vld_q) begin
              rsp.held     = 1'b1;
              rsp.page_out = pend_page_q;
            end
          end
          default: ;
        endcase

        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = rsp;
          pend_vld_d  = 1'b0;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iss_cnt_q    <= '0;
      s2_vld_q     <= 1'b0;
      valid_q      <= '0;
      own_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      conf_any_q   <= 1'b0;
      conf_excl_q  <= 1'b0;
      has_q        <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      iss_cnt_q    <= iss_cnt_d;
      s2_vld_q     <= s2_vld_d;
      valid_q      <= valid_d;
      own_found_q  <= own_found_d;
      free_found_q <= free_found_d;
      conf_any_q   <= conf_any_d;
      conf_excl_q  <= conf_excl_d;
      has_q        <= has_d;
      pend_vld_q   <= pend_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    s2_idx_q    <= s2_idx_d;
    own_idx_q   <= own_idx_d;
    own_excl_q  <= own_excl_d;
    own_gnt_q   <= own_gnt_d;
    free_idx_q  <= free_idx_d;
    pend_page_q <= pend_page_d;
    out_q       <= out_d;
  end

  // Checks
  `SELT_ASSERT_IMP(a_wr_only_acquire, ram_we,
    (state_q == ST_FINISH) && (req_q.opcode == OP_ACQUIRE),
    "slot write outside acquire decision")
  `SELT_ASSERT_NXT(a_finish_loads_out, (state_q == ST_FINISH) && out_free,
    out_valid_q && in_ready_o,
    "final result not loaded on finish")
  `SELT_ASSERT_IMP(a_pend_only_list, pend_vld_q, req_q.opcode == OP_LIST,
    "pending page outside list request")
  `SELT_ASSERT_IMP(a_stall_needs_busy_out, stall, out_valid_q && !out_ready_i,
    "scan stalled with output free")

endmodule

`default_nettype wire

// ===== design/selt_slot_ram.sv =====
`default_nettype none

module selt_slot_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [selt_pkg::IdxW-1:0] waddr_i,
  input  selt_pkg::entry_t          wdata_i,
  input  logic                      re_i,
  input  logic [selt_pkg::IdxW-1:0] raddr_i,
  output selt_pkg::entry_t          rdata_o
);
  import selt_pkg::*;

  entry_t mem_q [TableSlots];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== tb/sv/shared_exclusive_lock_table_top_test.sv =====
module shared_exclusive_lock_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import selt_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 2 * (TableSlots + 3);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_item_o;

  // Own copy of the lock table
  logic [31:0] tbl_page [TableSlots];
  logic [31:0] tbl_txn [TableSlots];
  logic tbl_valid [TableSlots];
  logic tbl_excl [TableSlots];
  logic tbl_granted [TableSlots];

  rsp_t expected_rsp_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int rsp_count = 0;

  shared_exclusive_lock_table_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Append one expected result at the tail
  function automatic void queue_expected(input rsp_t r);
    expected_rsp_q.insert(expected_rsp_q.size(), r);
  endfunction

  // Any granted entry on the page that clashes with the wanted mode
  function automatic logic page_conflict(input logic [31:0] pg, input logic excl);
    int i;
    for (i = 0; i < TableSlots; i++) begin
      if (tbl_valid[i] && tbl_granted[i] && tbl_page[i] == pg && (excl || tbl_excl[i]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one request to the table and queue the results it causes
  function automatic void predict_lock_request(input req_t r);
    int i;
    int own;
    int free_slot;
    logic grant;
    rsp_t rsp;
    rsp_t list_q [$];
    own = -1;
    free_slot = -1;
    rsp = '0;
    rsp.status = STAT_OK;
    rsp.last = 1'b1;
    case (r.opcode)
      OP_ACQUIRE: begin
        for (i = 0; i < TableSlots; i++) begin
          if (tbl_valid[i]) begin
            if (own < 0 && tbl_page[i] == r.page && tbl_txn[i] == r.txn) own = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (own >= 0) begin
          if (!tbl_excl[own] && r.want_exclusive && !page_conflict(r.page, 1'b1)) begin
            // upgrade in place, granted mark untouched
            tbl_excl[own] = 1'b1;
          end else begin
            rsp.status = tbl_granted[own] ? STAT_OK : STAT_WAIT;
          end
        end else if (free_slot < 0) begin
          rsp.status = STAT_FULL;
        end else begin
          grant = !page_conflict(r.page, r.want_exclusive);
          tbl_valid[free_slot] = 1'b1;
          tbl_page[free_slot] = r.page;
          tbl_txn[free_slot] = r.txn;
          tbl_excl[free_slot] = r.want_exclusive;
          tbl_granted[free_slot] = grant;
          rsp.status = grant ? STAT_OK : STAT_WAIT;
        end
        queue_expected(rsp);
      end
      OP_RELEASE, OP_REL_ALL: begin
        for (i = 0; i < TableSlots; i++) begin
          if (tbl_valid[i] && tbl_txn[i] == r.txn &&
              (r.opcode == OP_REL_ALL || tbl_page[i] == r.page))
            tbl_valid[i] = 1'b0;
        end
        queue_expected(rsp);
      end
      OP_HAS: begin
        for (i = 0; i < TableSlots; i++) begin
          if (tbl_valid[i] && tbl_granted[i] && tbl_page[i] == r.page &&
              tbl_txn[i] == r.txn)
            rsp.held = 1'b1;
        end
        queue_expected(rsp);
      end
      OP_LIST: begin
        for (i = 0; i < TableSlots; i++) begin
          if (tbl_valid[i] && tbl_granted[i] && tbl_txn[i] == r.txn) begin
            rsp.held = 1'b1;
            rsp.page_out = tbl_page[i];
            rsp.last = 1'b0;
            list_q.insert(list_q.size(), rsp);
          end
        end
        if (list_q.size() == 0) begin
          rsp = '0;
          rsp.last = 1'b1;
          list_q.insert(list_q.size(), rsp);
        end
        list_q[list_q.size() - 1].last = 1'b1;
        foreach (list_q[k]) queue_expected(list_q[k]);
      end
      default: queue_expected(rsp);
    endcase
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d: %p", rsp_count, out_item_o));
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (out_item_o.status !== exp_rsp.status)
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    rsp_count, out_item_o.status, exp_rsp.status));
        if (out_item_o.held !== exp_rsp.held)
          report_mismatch($sformatf("result %0d held got %0b want %0b",
                                    rsp_count, out_item_o.held, exp_rsp.held));
        if (out_item_o.page_out !== exp_rsp.page_out)
          report_mismatch($sformatf("result %0d page_out got %h want %h",
                                    rsp_count, out_item_o.page_out, exp_rsp.page_out));
        if (out_item_o.last !== exp_rsp.last)
          report_mismatch($sformatf("result %0d last got %0b want %0b",
                                    rsp_count, out_item_o.last, exp_rsp.last));
      end
      rsp_count++;
    end
  end

  // Send one request item; returns at the falling edge after acceptance
  task automatic send_request(input logic [2:0] op, input logic [31:0] pg,
                              input logic [31:0] tx, input logic wx);
    req_t r;
    r.opcode = op;
    r.page = pg;
    r.txn = tx;
    r.want_exclusive = wx;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_lock_request(r);
    @(negedge clk_i);
  endtask

  // Shared locks coexist, exclusive waits behind them
  task automatic test_shared_locks();
    send_request(OP_ACQUIRE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_request(OP_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_ACQUIRE, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
    send_request(OP_HAS, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
    send_request(OP_HAS, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    // own granted shared entry asked for exclusive: no upgrade while others hold
    send_request(OP_ACQUIRE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_request(OP_RELEASE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_request(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_ACQUIRE, 32'h0000_0000, 32'h0000_0000, 1'b1);
  endtask

  // Waiting shared entry turns exclusive once the page is free, still ungranted
  task automatic test_upgrade();
    send_request(OP_ACQUIRE, 32'h8000_0001, 32'h0000_00A5, 1'b1);
    send_request(OP_ACQUIRE, 32'h8000_0001, 32'h5A5A_0000, 1'b0);
    send_request(OP_RELEASE, 32'h8000_0001, 32'h0000_00A5, 1'b0);
    send_request(OP_ACQUIRE, 32'h8000_0001, 32'h5A5A_0000, 1'b1);
    send_request(OP_HAS, 32'h8000_0001, 32'h5A5A_0000, 1'b0);
    send_request(OP_ACQUIRE, 32'h8000_0001, 32'h5A5A_0000, 1'b0);
    send_request(OP_REL_ALL, 32'h7FFF_FFFE, 32'h5A5A_0000, 1'b0);
  endtask

  // List granted pages, skip waiting entries, and the empty answer
  task automatic test_list_pages();
    send_request(OP_ACQUIRE, 32'h5555_5555, 32'h0000_0000, 1'b0);
    send_request(OP_LIST, 32'hAAAA_AAAA, 32'h0000_0000, 1'b1);
    send_request(OP_LIST, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_LIST, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
    send_request(OP_REL_ALL, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_request(OP_REL_ALL, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
  endtask

  // Undefined opcodes answer done and touch nothing
  task automatic test_unknown_ops();
    int op;
    for (op = 5; op < 8; op++) send_request(op[2:0], $urandom, $urandom, op[0]);
  endtask

  // Empty the table, fill it, overflow it and list the full set
  task automatic test_table_full();
    int i;
    int busy;
    logic [31:0] tx;
    logic [31:0] base;
    tx = $urandom;
    base = $urandom;
    busy = 1;
    while (busy) begin
      busy = 0;
      for (i = 0; i < TableSlots; i++) begin
        if (tbl_valid[i] && !busy) begin
          busy = 1;
          send_request(OP_REL_ALL, $urandom, tbl_txn[i], 1'($urandom_range(1)));
        end
      end
    end
    for (i = 0; i < TableSlots; i++)
      send_request(OP_ACQUIRE, base + i, tx, 1'($urandom_range(1)));
    send_request(OP_ACQUIRE, base + TableSlots, tx, 1'($urandom_range(1)));
    // an existing entry is answered from its own marks even with the table full
    send_request(OP_ACQUIRE, base, tx, 1'($urandom_range(1)));
    send_request(OP_ACQUIRE, base + 1, $urandom, 1'b0);
    send_request(OP_LIST, $urandom, tx, 1'($urandom_range(1)));
    send_request(OP_RELEASE, base + 3, tx, 1'b0);
    send_request(OP_ACQUIRE, base + TableSlots, tx, 1'b0);
    send_request(OP_REL_ALL, $urandom, tx, 1'b0);
  endtask

  // Mixed traffic over small pools of pages and transactions so entries collide
  task automatic test_random_traffic(input int n_items);
    logic [31:0] txn_pool [5];
    logic [31:0] page_pool [8];
    int i;
    int pick;
    logic [31:0] pg;
    logic [31:0] tx;
    logic wx;
    foreach (txn_pool[k]) txn_pool[k] = $urandom;
    foreach (page_pool[k]) page_pool[k] = $urandom;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      pg = page_pool[$urandom_range(7)];
      tx = txn_pool[$urandom_range(4)];
      wx = 1'($urandom_range(1));
      if (pick < 42)      send_request(OP_ACQUIRE, pg, tx, wx);
      else if (pick < 54) send_request(OP_RELEASE, pg, tx, wx);
      else if (pick < 59) send_request(OP_REL_ALL, $urandom, tx, wx);
      else if (pick < 73) send_request(OP_HAS, pg, tx, wx);
      else if (pick < 85) send_request(OP_LIST, $urandom, tx, wx);
      else if (pick < 90) send_request(3'($urandom_range(7, 5)), $urandom, $urandom, wx);
      else                send_request(3'($urandom_range(3)), $urandom, $urandom, wx);
    end
  endtask

  initial begin
    // Start with an empty table
    foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;

    // Hold reset, then release at a falling edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_shared_locks();
    test_upgrade();
    test_list_pages();
    test_unknown_ops();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_table_full();
    test_random_traffic(60);

    send_idle_pct = 57;
    recv_stall_pct = 0;
    test_random_traffic(60);

    send_idle_pct = 0;
    recv_stall_pct = 57;
    test_random_traffic(60);
    test_table_full();

    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_random_traffic(60);

    // Drain outstanding results
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/selt_pkg.sv
design/selt_slot_ram.sv
design/shared_exclusive_lock_table_top.sv
tb/sv/shared_exclusive_lock_table_top_test.sv
